// ----- design/wbp_pkg.sv -----
// wbp_pkg: shared constants, opcode and register codes, and the structs that
// pass between the window binary pattern sequencer, coordinate unit and top level.
// No dependencies.
package wbp_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_WINDOW_DEF = 7;
  localparam int PIXEL_BITS_DEF = 16;

  // Fixed field widths
  localparam int COL_BITS       = 10;
  localparam int LIGHT_BITS     = 16;
  localparam int PATTERN_BITS   = 49;
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 2;
  localparam int WSIDE_BITS     = 3;

  // Internal widths, large enough for every legal parameter value
  localparam int COORD_BITS   = 13;  // unsigned coordinate up to 4096
  localparam int SCOORD_BITS  = 14;  // signed coordinate before clamping
  localparam int SIDE_BITS    = 4;   // window side up to 8
  localparam int HALF_BITS    = 3;   // half window up to 3
  localparam int BIT_IDX_BITS = 6;   // pattern bit position up to 63

  // Transaction opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIDE  = 2'd2;

  // Effective image and window geometry
  typedef struct packed {
    logic [COORD_BITS-1:0] w_last;
    logic [COORD_BITS-1:0] h_last;
    logic [SIDE_BITS-1:0]  side;
    logic [HALF_BITS-1:0]  half;
  } geom_t;

  // One read request into the coordinate unit
  typedef struct packed {
    logic                          valid;
    logic                          is_centre;
    logic [BIT_IDX_BITS-1:0]       bit_idx;
    logic signed [SCOORD_BITS-1:0] x;
    logic signed [SCOORD_BITS-1:0] y;
  } coord_req_t;

  // Tag that travels alongside a frame store read
  typedef struct packed {
    logic                    valid;
    logic                    is_centre;
    logic [BIT_IDX_BITS-1:0] bit_idx;
  } coord_tag_t;

endpackage

// ----- design/wbp_frame_store.sv -----
// wbp_frame_store: lightness plane memory, one write port and one registered
// read port. Depends on nothing but its parameters.
module wbp_frame_store #(
  parameter int DEPTH      = 1048576,
  parameter int AW         = 20,
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [PIXEL_BITS-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [PIXEL_BITS-1:0] rd_data
);

  logic [PIXEL_BITS-1:0] mem [DEPTH];

  // Store a pixel
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read a pixel, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/wbp_coord_unit.sv -----
// wbp_coord_unit: clamps each requested window coordinate to the image,
// registers it and forms the frame store read address. Uses wbp_pkg.
module wbp_coord_unit #(
  parameter int MAX_WIDTH = wbp_pkg::MAX_WIDTH_DEF,
  parameter int AW        = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  wbp_pkg::geom_t      geom,
  input  wbp_pkg::coord_req_t req,
  output wbp_pkg::coord_tag_t tag,
  output logic [AW-1:0]       rd_addr
);

  logic [wbp_pkg::COORD_BITS-1:0] nx_next, ny_next;
  logic [wbp_pkg::COORD_BITS-1:0] nx, ny;
  logic [31:0]                    addr_wide;

  // Clamp the coordinates to the image edges
  always_comb begin
    if (req.x < 0) begin
      nx_next = '0;
    end else if (req.x > $signed({1'b0, geom.w_last})) begin
      nx_next = geom.w_last;
    end else begin
      nx_next = req.x[wbp_pkg::COORD_BITS-1:0];
    end
    if (req.y < 0) begin
      ny_next = '0;
    end else if (req.y > $signed({1'b0, geom.h_last})) begin
      ny_next = geom.h_last;
    end else begin
      ny_next = req.y[wbp_pkg::COORD_BITS-1:0];
    end
  end

  // Hold the clamped coordinates and their tag
  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid     <= req.valid;
      tag.is_centre <= req.is_centre;
      tag.bit_idx   <= req.bit_idx;
      nx            <= nx_next;
      ny            <= ny_next;
    end
  end

  // Row-major address into the frame store
  assign addr_wide = 32'(ny) * 32'(MAX_WIDTH) + 32'(nx);
  assign rd_addr   = addr_wide[AW-1:0];

endmodule

// ----- design/wbp_seq.sv -----
// wbp_seq: transaction handshake, write path, window sequencer, shared
// comparator and result register. Uses wbp_pkg.
module wbp_seq #(
  parameter int MAX_WIDTH  = wbp_pkg::MAX_WIDTH_DEF,
  parameter int AW         = 20,
  parameter int PIXEL_BITS = wbp_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wbp_pkg::geom_t                      geom,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [wbp_pkg::COL_BITS-1:0]        col,
  input  logic [wbp_pkg::COL_BITS-1:0]        row,
  input  logic [wbp_pkg::LIGHT_BITS-1:0]      lightness,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wbp_pkg::PATTERN_BITS-1:0]    pattern_bits,
  output wbp_pkg::coord_req_t                 req,
  input  wbp_pkg::coord_tag_t                 tag,
  output logic                                wr_en,
  output logic [AW-1:0]                       wr_addr,
  output logic [PIXEL_BITS-1:0]               wr_data,
  input  logic [PIXEL_BITS-1:0]               rd_data
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN} state_t;

  state_t                              state;
  logic [wbp_pkg::COORD_BITS-1:0]      qx, qy;
  logic [wbp_pkg::COORD_BITS-1:0]      col_ext, row_ext;
  logic                                first;
  logic [wbp_pkg::SIDE_BITS-1:0]       c_cnt, r_cnt;
  logic [wbp_pkg::BIT_IDX_BITS-1:0]    bit_cnt;
  wbp_pkg::coord_tag_t                 d_tag;
  logic [PIXEL_BITS-1:0]               centre;
  logic [wbp_pkg::PATTERN_BITS-1:0]    pattern;
  logic                                accept;
  logic                                slot_free;
  logic                                pipe_empty;
  logic [wbp_pkg::SIDE_BITS-1:0]       side_last;
  logic signed [wbp_pkg::SCOORD_BITS-1:0] qx_s, qy_s, half_s, c_s, r_s;
  logic [31:0]                         wr_addr_wide;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && (state == S_IDLE);
  assign slot_free  = !out_valid || !out_stall;
  assign pipe_empty = !tag.valid && !d_tag.valid;
  assign side_last  = geom.side - 4'd1;
  assign col_ext    = wbp_pkg::COORD_BITS'(col);
  assign row_ext    = wbp_pkg::COORD_BITS'(row);

  // Write path: drop writes that fall outside the image in use
  assign wr_addr_wide = 32'(row_ext) * 32'(MAX_WIDTH) + 32'(col_ext);
  assign wr_addr      = wr_addr_wide[AW-1:0];
  assign wr_data      = PIXEL_BITS'(lightness);
  assign wr_en        = accept && (opcode == wbp_pkg::OP_WRITE) &&
                        (col_ext <= geom.w_last) && (row_ext <= geom.h_last);

  // Window request: centre first, then each neighbour in raster order
  assign qx_s   = $signed({1'b0, qx});
  assign qy_s   = $signed({1'b0, qy});
  assign half_s = $signed({{(wbp_pkg::SCOORD_BITS-wbp_pkg::HALF_BITS){1'b0}}, geom.half});
  assign c_s    = $signed({{(wbp_pkg::SCOORD_BITS-wbp_pkg::SIDE_BITS){1'b0}}, c_cnt});
  assign r_s    = $signed({{(wbp_pkg::SCOORD_BITS-wbp_pkg::SIDE_BITS){1'b0}}, r_cnt});

  always_comb begin
    req.valid     = (state == S_ISSUE);
    req.is_centre = first;
    req.bit_idx   = bit_cnt;
    if (first) begin
      req.x = qx_s;
      req.y = qy_s;
    end else begin
      req.x = qx_s - half_s + c_s;
      req.y = qy_s - half_s + r_s;
    end
  end

  // Sequencer, comparator and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      d_tag.valid <= 1'b0;
    end else begin
      d_tag <= tag;

      // Latch the centre, then compare each neighbour against it
      if (d_tag.valid) begin
        if (d_tag.is_centre) begin
          centre <= rd_data;
        end else if ((rd_data > centre) &&
                     (d_tag.bit_idx < wbp_pkg::BIT_IDX_BITS'(wbp_pkg::PATTERN_BITS))) begin
          pattern[d_tag.bit_idx] <= 1'b1;
        end
      end

      // Release a result once taken, unless the next one loads at this edge
      if (out_valid && !out_stall && !((state == S_DRAIN) && pipe_empty)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && (opcode == wbp_pkg::OP_QUERY)) begin
            qx      <= (col_ext > geom.w_last) ? geom.w_last : col_ext;
            qy      <= (row_ext > geom.h_last) ? geom.h_last : row_ext;
            first   <= 1'b1;
            c_cnt   <= '0;
            r_cnt   <= '0;
            bit_cnt <= '0;
            pattern <= '0;
            state   <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (first) begin
            first <= 1'b0;
          end else begin
            bit_cnt <= bit_cnt + 1'b1;
            if (c_cnt == side_last) begin
              c_cnt <= '0;
              if (r_cnt == side_last) begin
                state <= S_DRAIN;
              end else begin
                r_cnt <= r_cnt + 1'b1;
              end
            end else begin
              c_cnt <= c_cnt + 1'b1;
            end
          end
        end
        S_DRAIN: begin
          // Wait for the last compare, then hand over the pattern
          if (pipe_empty && slot_free) begin
            pattern_bits <= pattern;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/window_binary_pattern.sv -----
// window_binary_pattern: top level with configuration registers, geometry
// clamping and the sequencer, coordinate unit and frame store. Uses wbp_pkg.
//
// A write transaction stores one pixel and never stalls the next transaction.
// Between its acceptance and the acceptance of the next transaction, a query
// transaction makes one read of the centre and one read per window pixel
// through the single frame-store read port, lets the registered memory read
// and the compare drain, loads the result register once it is free and
// returns to idle, where the next transaction is taken. A result waiting on
// out_stall does not block writes. The frame store has no clearing pass: a
// query may only touch pixels written since reset. Configuration is written
// through cfg_we, cfg_index, cfg_wdata; the user must write it only while no
// transaction is in progress, as the block itself does not enforce this.
module window_binary_pattern #(
  parameter int MAX_WIDTH  = wbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wbp_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WINDOW = wbp_pkg::MAX_WINDOW_DEF,
  parameter int PIXEL_BITS = wbp_pkg::PIXEL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wbp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [wbp_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic [wbp_pkg::COL_BITS-1:0]         col,
  input  logic [wbp_pkg::COL_BITS-1:0]         row,
  input  logic [wbp_pkg::LIGHT_BITS-1:0]       lightness,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wbp_pkg::PATTERN_BITS-1:0]     pattern_bits
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [wbp_pkg::CFG_DATA_BITS-1:0] image_width, image_height;
  logic [wbp_pkg::WSIDE_BITS-1:0]    window_side;
  logic [wbp_pkg::COORD_BITS-1:0]    w_ext, h_ext, w_eff, h_eff;
  logic [wbp_pkg::SIDE_BITS-1:0]     s_ext, s_eff;
  wbp_pkg::geom_t                    geom;
  wbp_pkg::coord_req_t               req;
  wbp_pkg::coord_tag_t               tag;
  logic [AW-1:0]                     rd_addr, wr_addr;
  logic                              wr_en;
  logic [PIXEL_BITS-1:0]             wr_data, rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= wbp_pkg::CFG_DATA_BITS'(1024);
      image_height <= wbp_pkg::CFG_DATA_BITS'(1024);
      window_side  <= wbp_pkg::WSIDE_BITS'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbp_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
        wbp_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        wbp_pkg::REG_WINDOW_SIDE:  window_side  <= cfg_wdata[wbp_pkg::WSIDE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp sizes to one and to the built maxima
  assign w_ext = wbp_pkg::COORD_BITS'(image_width);
  assign h_ext = wbp_pkg::COORD_BITS'(image_height);
  assign s_ext = wbp_pkg::SIDE_BITS'(window_side);

  always_comb begin
    if (w_ext == '0) begin
      w_eff = wbp_pkg::COORD_BITS'(1);
    end else if (w_ext > wbp_pkg::COORD_BITS'(MAX_WIDTH)) begin
      w_eff = wbp_pkg::COORD_BITS'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = wbp_pkg::COORD_BITS'(1);
    end else if (h_ext > wbp_pkg::COORD_BITS'(MAX_HEIGHT)) begin
      h_eff = wbp_pkg::COORD_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    if (s_ext == '0) begin
      s_eff = wbp_pkg::SIDE_BITS'(1);
    end else if (s_ext > wbp_pkg::SIDE_BITS'(MAX_WINDOW)) begin
      s_eff = wbp_pkg::SIDE_BITS'(MAX_WINDOW);
    end else begin
      s_eff = s_ext;
    end
    geom.w_last = w_eff - 1'b1;
    geom.h_last = h_eff - 1'b1;
    geom.side   = s_eff;
    geom.half   = wbp_pkg::HALF_BITS'((s_eff - 1'b1) >> 1);
  end

  wbp_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .AW         (AW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .geom         (geom),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .col          (col),
    .row          (row),
    .lightness    (lightness),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pattern_bits (pattern_bits),
    .req          (req),
    .tag          (tag),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_data      (rd_data)
  );

  wbp_coord_unit #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_coord (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .req     (req),
    .tag     (tag),
    .rd_addr (rd_addr)
  );

  wbp_frame_store #(
    .DEPTH      (DEPTH),
    .AW         (AW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (tag.valid),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ----- design/wbp_checker.sv -----
// wbp_checker: port-level assertions for window_binary_pattern, attached by
// the bind statement at the end of this file. Uses wbp_pkg.
module wbp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             opcode,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [wbp_pkg::PATTERN_BITS-1:0] pattern_bits
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pattern_bits))
    else $error("stalled result changed or dropped");

  // Stall after a query transaction is taken
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == wbp_pkg::OP_QUERY) |=> in_stall)
    else $error("query accepted without the block going busy");

  // Keep taking transactions after a write
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == wbp_pkg::OP_WRITE) |=> !in_stall)
    else $error("write transaction left the block busy");

  // A result only appears at the end of a query
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a query in progress");

endmodule

bind window_binary_pattern wbp_checker u_wbp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .opcode       (opcode),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pattern_bits (pattern_bits)
);
